>>> hw/rtl/matrix_alu_4x4_top_assert.svh
// Assertion macros for the matrix ALU.
`ifndef MATRIX_ALU_4X4_TOP_ASSERT_SVH
`define MATRIX_ALU_4X4_TOP_ASSERT_SVH

// Property checked at every rising clock edge outside reset.
`define MXA_CHECK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("matrix ALU check failed");

// Antecedent in one cycle implies consequent in the next.
`define MXA_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("matrix ALU sequencing check failed");

`endif

>>> hw/rtl/mxalu_pkg.sv
package mxalu_pkg;

    localparam int IDX_W     = 2;
    localparam int ELEM_W    = 8;
    localparam int VAL_W     = 34;
    localparam int TERM_W    = 5;
    localparam int DET_TERMS = 24;

    typedef enum logic [2:0] {
        ACT_LOAD_A = 3'd0,
        ACT_LOAD_B = 3'd1,
        ACT_MUL    = 3'd2,
        ACT_ADD    = 3'd3,
        ACT_SUB    = 3'd4,
        ACT_DET    = 3'd5,
        ACT_TRANS  = 3'd6,
        ACT_SCALE  = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_ACC,
        S_PUT
    } t_state;

    typedef enum logic [1:0] {
        FS_A,
        FS_B,
        FS_SCALE,
        FS_IDENT
    } t_fsrc;

    typedef struct packed {
        logic             cmd_start;
        logic             mul_en;
        logic             first_fac;
        t_fsrc            fsrc;
        logic             ident_one;
        logic             acc_en;
        logic             first_term;
        logic             neg;
        logic             put;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_dp_ctrl;

    // Permutations of four columns in lexicographic order: {odd, p0, p1, p2, p3}.
    function automatic logic [8:0] det_perm(input logic [TERM_W-1:0] k);
        case (k)
            5'd0:    return {1'b0, 2'd0, 2'd1, 2'd2, 2'd3};
            5'd1:    return {1'b1, 2'd0, 2'd1, 2'd3, 2'd2};
            5'd2:    return {1'b1, 2'd0, 2'd2, 2'd1, 2'd3};
            5'd3:    return {1'b0, 2'd0, 2'd2, 2'd3, 2'd1};
            5'd4:    return {1'b0, 2'd0, 2'd3, 2'd1, 2'd2};
            5'd5:    return {1'b1, 2'd0, 2'd3, 2'd2, 2'd1};
            5'd6:    return {1'b1, 2'd1, 2'd0, 2'd2, 2'd3};
            5'd7:    return {1'b0, 2'd1, 2'd0, 2'd3, 2'd2};
            5'd8:    return {1'b0, 2'd1, 2'd2, 2'd0, 2'd3};
            5'd9:    return {1'b1, 2'd1, 2'd2, 2'd3, 2'd0};
            5'd10:   return {1'b1, 2'd1, 2'd3, 2'd0, 2'd2};
            5'd11:   return {1'b0, 2'd1, 2'd3, 2'd2, 2'd0};
            5'd12:   return {1'b0, 2'd2, 2'd0, 2'd1, 2'd3};
            5'd13:   return {1'b1, 2'd2, 2'd0, 2'd3, 2'd1};
            5'd14:   return {1'b1, 2'd2, 2'd1, 2'd0, 2'd3};
            5'd15:   return {1'b0, 2'd2, 2'd1, 2'd3, 2'd0};
            5'd16:   return {1'b0, 2'd2, 2'd3, 2'd0, 2'd1};
            5'd17:   return {1'b1, 2'd2, 2'd3, 2'd1, 2'd0};
            5'd18:   return {1'b1, 2'd3, 2'd0, 2'd1, 2'd2};
            5'd19:   return {1'b0, 2'd3, 2'd0, 2'd2, 2'd1};
            5'd20:   return {1'b0, 2'd3, 2'd1, 2'd0, 2'd2};
            5'd21:   return {1'b1, 2'd3, 2'd1, 2'd2, 2'd0};
            5'd22:   return {1'b1, 2'd3, 2'd2, 2'd0, 2'd1};
            5'd23:   return {1'b0, 2'd3, 2'd2, 2'd1, 2'd0};
            default: return '0;
        endcase
    endfunction

endpackage

>>> hw/rtl/mxalu_ram.sv
module mxalu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/mxalu_seq.sv
`include "matrix_alu_4x4_top_assert.svh"

module mxalu_seq #(
    parameter int DIM = 4,
    parameter int AW  = $clog2(DIM * DIM)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [2:0]                       i_action,
    input  logic [mxalu_pkg::IDX_W-1:0]      i_row,
    input  logic [mxalu_pkg::IDX_W-1:0]      i_col,
    input  logic                             i_which_matrix,
    input  logic                             i_out_free,
    output logic                             o_we_a,
    output logic                             o_we_b,
    output logic [AW-1:0]                    o_waddr,
    output logic [AW-1:0]                    o_raddr,
    output mxalu_pkg::t_dp_ctrl              o_ctrl
);

    mxalu_pkg::t_state                    r_state, n_state;
    mxalu_pkg::t_action                   r_act, n_act;
    logic                                 r_sel, n_sel;
    logic [mxalu_pkg::IDX_W-1:0]          r_i, n_i;
    logic [mxalu_pkg::IDX_W-1:0]          r_j, n_j;
    logic [mxalu_pkg::TERM_W-1:0]         r_term, n_term;
    logic [1:0]                           r_fac, n_fac;

    mxalu_pkg::t_action                   in_act;
    logic                                 in_is_load;
    logic                                 load_ok;
    logic [mxalu_pkg::TERM_W-1:0]         term_last;
    logic [1:0]                           fac_last;
    logic [mxalu_pkg::IDX_W-1:0]          rr, cc;
    mxalu_pkg::t_fsrc                     fsrc;
    mxalu_pkg::t_fsrc                     sel_src;
    logic                                 neg;
    logic [8:0]                           perm;
    logic                                 last_elem;
    logic                                 put_more;

    function automatic logic [AW-1:0] addr_of(input logic [mxalu_pkg::IDX_W-1:0] r,
                                             input logic [mxalu_pkg::IDX_W-1:0] c);
        return AW'(int'(r) * DIM + int'(c));
    endfunction

    assign in_act     = mxalu_pkg::t_action'(i_action);
    assign in_is_load = (in_act == mxalu_pkg::ACT_LOAD_A) || (in_act == mxalu_pkg::ACT_LOAD_B);
    assign load_ok    = (int'(i_row) < DIM) && (int'(i_col) < DIM);
    assign o_in_ready = (r_state == mxalu_pkg::S_IDLE);
    assign o_we_a     = o_in_ready && i_in_valid && load_ok && (in_act == mxalu_pkg::ACT_LOAD_A);
    assign o_we_b     = o_in_ready && i_in_valid && load_ok && (in_act == mxalu_pkg::ACT_LOAD_B);
    assign o_waddr    = addr_of(i_row, i_col);
    assign o_raddr    = addr_of(rr, cc);
    assign perm       = mxalu_pkg::det_perm(r_term);
    assign sel_src    = r_sel ? mxalu_pkg::FS_B : mxalu_pkg::FS_A;
    assign last_elem  = (r_act == mxalu_pkg::ACT_DET)
                     || ((r_i == mxalu_pkg::IDX_W'(DIM - 1)) && (r_j == mxalu_pkg::IDX_W'(DIM - 1)));
    assign put_more   = (r_state == mxalu_pkg::S_PUT) && i_out_free && !last_elem;

    // Each result element is a signed sum of terms, each term a product of factors.
    always_comb begin
        term_last = '0;
        fac_last  = '0;
        rr        = r_i;
        cc        = r_j;
        fsrc      = sel_src;
        neg       = 1'b0;
        case (r_act)
            mxalu_pkg::ACT_MUL: begin
                term_last = mxalu_pkg::TERM_W'(DIM - 1);
                fac_last  = 2'd1;
                rr        = (r_fac == 2'd0) ? r_i : r_term[1:0];
                cc        = (r_fac == 2'd0) ? r_term[1:0] : r_j;
                fsrc      = (r_fac == 2'd0) ? mxalu_pkg::FS_A : mxalu_pkg::FS_B;
            end
            mxalu_pkg::ACT_ADD, mxalu_pkg::ACT_SUB: begin
                term_last = mxalu_pkg::TERM_W'(1);
                fsrc      = r_term[0] ? mxalu_pkg::FS_B : mxalu_pkg::FS_A;
                neg       = r_term[0] && (r_act == mxalu_pkg::ACT_SUB);
            end
            mxalu_pkg::ACT_TRANS: begin
                rr = r_j;
                cc = r_i;
            end
            mxalu_pkg::ACT_SCALE: begin
                fac_last = 2'd1;
                fsrc     = (r_fac == 2'd0) ? sel_src : mxalu_pkg::FS_SCALE;
            end
            mxalu_pkg::ACT_DET: begin
                term_last = mxalu_pkg::TERM_W'(mxalu_pkg::DET_TERMS - 1);
                fac_last  = 2'd3;
                rr        = r_fac;
                case (r_fac)
                    2'd0:    cc = perm[7:6];
                    2'd1:    cc = perm[5:4];
                    2'd2:    cc = perm[3:2];
                    default: cc = perm[1:0];
                endcase
                // Rows and columns at DIM or above act as the identity.
                if ((int'(rr) >= DIM) || (int'(cc) >= DIM)) begin
                    fsrc = mxalu_pkg::FS_IDENT;
                end
                neg = perm[8];
            end
            default: begin
                term_last = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        n_sel   = r_sel;
        n_i     = r_i;
        n_j     = r_j;
        n_term  = r_term;
        n_fac   = r_fac;

        o_ctrl            = '0;
        o_ctrl.fsrc       = fsrc;
        o_ctrl.ident_one  = (rr == cc);
        o_ctrl.first_fac  = (r_fac == 2'd0);
        o_ctrl.first_term = (r_term == '0);
        o_ctrl.neg        = neg;
        o_ctrl.row        = r_i;
        o_ctrl.col        = r_j;
        o_ctrl.last       = last_elem;

        case (r_state)
            mxalu_pkg::S_IDLE: begin
                if (i_in_valid && !in_is_load) begin
                    o_ctrl.cmd_start = 1'b1;
                    n_act   = in_act;
                    n_sel   = i_which_matrix;
                    n_i     = '0;
                    n_j     = '0;
                    n_term  = '0;
                    n_fac   = '0;
                    n_state = mxalu_pkg::S_RD;
                end
            end
            mxalu_pkg::S_RD: begin
                n_state = mxalu_pkg::S_MUL;
            end
            mxalu_pkg::S_MUL: begin
                o_ctrl.mul_en = 1'b1;
                if (r_fac == fac_last) begin
                    n_fac   = '0;
                    n_state = mxalu_pkg::S_ACC;
                end else begin
                    n_fac   = r_fac + 2'd1;
                    n_state = mxalu_pkg::S_RD;
                end
            end
            mxalu_pkg::S_ACC: begin
                o_ctrl.acc_en = 1'b1;
                if (r_term == term_last) begin
                    n_term  = '0;
                    n_state = mxalu_pkg::S_PUT;
                end else begin
                    n_term  = r_term + mxalu_pkg::TERM_W'(1);
                    n_state = mxalu_pkg::S_RD;
                end
            end
            mxalu_pkg::S_PUT: begin
                if (i_out_free) begin
                    o_ctrl.put = 1'b1;
                    if (last_elem) begin
                        n_state = mxalu_pkg::S_IDLE;
                    end else begin
                        n_state = mxalu_pkg::S_RD;
                        if (r_j == mxalu_pkg::IDX_W'(DIM - 1)) begin
                            n_j = '0;
                            n_i = r_i + mxalu_pkg::IDX_W'(1);
                        end else begin
                            n_j = r_j + mxalu_pkg::IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = mxalu_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mxalu_pkg::S_IDLE;
            r_act   <= mxalu_pkg::ACT_LOAD_A;
            r_sel   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_term  <= '0;
            r_fac   <= '0;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
            r_sel   <= n_sel;
            r_i     <= n_i;
            r_j     <= n_j;
            r_term  <= n_term;
            r_fac   <= n_fac;
        end
    end

    `MXA_CHECK(a_fac_bound, (r_state != mxalu_pkg::S_IDLE) |-> (r_fac <= fac_last))
    `MXA_CHECK(a_term_bound, (r_state != mxalu_pkg::S_IDLE) |-> (r_term <= term_last))
    `MXA_CHECK_NEXT(a_put_advance, put_more, r_state == mxalu_pkg::S_RD)

endmodule

>>> hw/rtl/mxalu_dp.sv
`include "matrix_alu_4x4_top_assert.svh"

module mxalu_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mxalu_pkg::t_dp_ctrl                    i_ctrl,
    input  logic signed [mxalu_pkg::ELEM_W-1:0]    i_scale_factor,
    input  logic signed [mxalu_pkg::ELEM_W-1:0]    i_rdata_a,
    input  logic signed [mxalu_pkg::ELEM_W-1:0]    i_rdata_b,
    input  logic                                   i_out_ready,
    output logic                                   o_out_free,
    output logic                                   o_out_valid,
    output logic [mxalu_pkg::IDX_W-1:0]            o_out_row,
    output logic [mxalu_pkg::IDX_W-1:0]            o_out_col,
    output logic signed [mxalu_pkg::VAL_W-1:0]     o_out_value,
    output logic                                   o_last
);

    localparam int PROD_W = mxalu_pkg::VAL_W + mxalu_pkg::ELEM_W;

    logic signed [mxalu_pkg::ELEM_W-1:0] r_scale;
    logic signed [mxalu_pkg::VAL_W-1:0]  r_prod, n_prod;
    logic signed [mxalu_pkg::VAL_W-1:0]  r_acc, n_acc;
    logic                                r_out_valid;
    logic [mxalu_pkg::IDX_W-1:0]         r_out_row;
    logic [mxalu_pkg::IDX_W-1:0]         r_out_col;
    logic signed [mxalu_pkg::VAL_W-1:0]  r_out_value;
    logic                                r_last;

    logic signed [mxalu_pkg::ELEM_W-1:0] factor;
    logic signed [mxalu_pkg::VAL_W-1:0]  mul_a;
    logic signed [PROD_W-1:0]            mul_p;
    logic signed [mxalu_pkg::VAL_W-1:0]  acc_base;

    always_comb begin
        case (i_ctrl.fsrc)
            mxalu_pkg::FS_A:     factor = i_rdata_a;
            mxalu_pkg::FS_B:     factor = i_rdata_b;
            mxalu_pkg::FS_SCALE: factor = r_scale;
            default:             factor = i_ctrl.ident_one ? 8'sd1 : 8'sd0;
        endcase
    end

    assign mul_a    = i_ctrl.first_fac ? mxalu_pkg::VAL_W'(1) : r_prod;
    assign mul_p    = mul_a * factor;
    assign n_prod   = i_ctrl.mul_en ? mul_p[mxalu_pkg::VAL_W-1:0] : r_prod;
    assign acc_base = i_ctrl.first_term ? '0 : r_acc;
    assign n_acc    = !i_ctrl.acc_en ? r_acc
                    : (i_ctrl.neg ? (acc_base - r_prod) : (acc_base + r_prod));

    assign o_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_acc  <= n_acc;
        if (i_ctrl.cmd_start) begin
            r_scale <= i_scale_factor;
        end
        if (i_ctrl.put) begin
            r_out_row   <= i_ctrl.row;
            r_out_col   <= i_ctrl.col;
            r_out_value <= r_acc;
            r_last      <= i_ctrl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.put) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_last      = r_last;

    `MXA_CHECK(a_no_overwrite, i_ctrl.put |-> (!r_out_valid || i_out_ready))
    `MXA_CHECK_NEXT(a_put_valid, i_ctrl.put, r_out_valid)

endmodule

>>> hw/rtl/matrix_alu_4x4_top.sv
// Channel | Handshake                  | Payload
// in      | i_in_valid / o_in_ready    | i_action i_row i_col i_value i_which_matrix
//         |                            | i_scale_factor
// out     | o_out_valid / i_out_ready  | o_out_row o_out_col o_out_value o_last
//
// A command runs term by term through one multiplier and one accumulator: each factor
// passes a RAM read and a multiply state, each term an accumulate state, each element
// an output state. Terms per element: multiply DIM, add/subtract 2, transpose 1,
// scale 1, determinant 24; factors per term 2, 1, 1, 2 and 4. Input is taken only
// while the sequencer is idle; the output register lets the next transaction start
// while the last result waits. Reset is synchronous, active low.
module matrix_alu_4x4_top #(
    parameter int DIM = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [2:0]                             i_action,
    input  logic [mxalu_pkg::IDX_W-1:0]            i_row,
    input  logic [mxalu_pkg::IDX_W-1:0]            i_col,
    input  logic signed [mxalu_pkg::ELEM_W-1:0]    i_value,
    input  logic                                   i_which_matrix,
    input  logic signed [mxalu_pkg::ELEM_W-1:0]    i_scale_factor,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [mxalu_pkg::IDX_W-1:0]            o_out_row,
    output logic [mxalu_pkg::IDX_W-1:0]            o_out_col,
    output logic signed [mxalu_pkg::VAL_W-1:0]     o_out_value,
    output logic                                   o_last
);

    localparam int DEPTH = DIM * DIM;
    localparam int AW    = $clog2(DEPTH);

    mxalu_pkg::t_dp_ctrl          ctrl;
    logic                         out_free;
    logic                         we_a, we_b;
    logic [AW-1:0]                waddr, raddr;
    logic [mxalu_pkg::ELEM_W-1:0] rdata_a, rdata_b;

    mxalu_seq #(
        .DIM(DIM),
        .AW (AW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_which_matrix(i_which_matrix),
        .i_out_free    (out_free),
        .o_we_a        (we_a),
        .o_we_b        (we_b),
        .o_waddr       (waddr),
        .o_raddr       (raddr),
        .o_ctrl        (ctrl)
    );

    mxalu_ram #(
        .WIDTH(mxalu_pkg::ELEM_W),
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_ram_a (
        .i_clk  (i_clk),
        .i_we   (we_a),
        .i_waddr(waddr),
        .i_wdata(i_value),
        .i_raddr(raddr),
        .o_rdata(rdata_a)
    );

    mxalu_ram #(
        .WIDTH(mxalu_pkg::ELEM_W),
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_ram_b (
        .i_clk  (i_clk),
        .i_we   (we_b),
        .i_waddr(waddr),
        .i_wdata(i_value),
        .i_raddr(raddr),
        .o_rdata(rdata_b)
    );

    mxalu_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_scale_factor(i_scale_factor),
        .i_rdata_a     (rdata_a),
        .i_rdata_b     (rdata_b),
        .i_out_ready   (i_out_ready),
        .o_out_free    (out_free),
        .o_out_valid   (o_out_valid),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_out_value   (o_out_value),
        .o_last        (o_last)
    );

endmodule
